[rtl/core/srg_pkg.sv]
// shared constants, codes and controller/datapath interface types
`timescale 1ns / 1ps
`default_nettype none
package srg_pkg;

    // default configuration of the top level
    localparam int SPEED_FRAC_BITS_DEF = 16;
    localparam int TIME_WIDTH_DEF      = 32;

    // field widths
    localparam int SPEED_INT_W = 14;
    localparam int ACCEL_W     = 20;
    localparam int DTIME_W     = 20;
    localparam int PWIDTH_W    = 16;
    localparam int IVAL_W      = 20;
    localparam int COUNT_W     = 32;
    localparam int NOW_W       = 32;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 20;
    localparam int QUOT_W      = 63;

    // one second in microseconds and its bit count
    localparam int USEC_W = 20;
    localparam logic [USEC_W-1:0] USEC = 20'd1000000;

    // quotient saturation point
    localparam logic [QUOT_W-1:0] QCAP = {1'b1, {(QUOT_W-1){1'b0}}};

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPEED  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MID_SPEED  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_SLOW = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_FAST = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DECEL_TIME = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_W    = 3'd6;

    // register reset values
    localparam logic [SPEED_INT_W-1:0] RST_MIN_SPEED  = 14'd80;
    localparam logic [SPEED_INT_W-1:0] RST_MID_SPEED  = 14'd400;
    localparam logic [SPEED_INT_W-1:0] RST_MAX_SPEED  = 14'd10000;
    localparam logic [ACCEL_W-1:0]     RST_ACCEL_SLOW = 20'd1000;
    localparam logic [ACCEL_W-1:0]     RST_ACCEL_FAST = 20'd64000;
    localparam logic [DTIME_W-1:0]     RST_DECEL_TIME = 20'd15000;
    localparam logic [PWIDTH_W-1:0]    RST_PULSE_W    = 16'd50;
    localparam logic [ACCEL_W-1:0]     RST_DECEL_RATE = 20'd64000;

    // run modes
    localparam logic [1:0] MODE_STOP = 2'd0;
    localparam logic [1:0] MODE_SLOW = 2'd1;
    localparam logic [1:0] MODE_FAST = 2'd2;
    localparam logic [1:0] MODE_DEC  = 2'd3;

    // controller to datapath commands
    typedef struct packed {
        logic load_in;
        logic fall_chk;
        logic mark_step;
        logic upd_speed;
        logic limit;
        logic do_step;
        logic park;
        logic set_ival;
        logic laser_cap;
        logic mul_step;
        logic start_rate;
        logic set_rate;
        logic out_load;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic is_laser;
        logic elapsed;
        logic mode_zero;
        logic mul_last;
        logic div_done;
        logic out_free;
    } t_dp_stat;

endpackage
`default_nettype wire

[rtl/core/stepper_ramp_homing_pulse_generator.sv]
// top level of one stepper ramp channel with laser homing
// One item at a time. A tick whose step interval has not run out runs no
// division; a tick that steps runs two divisions on the shared bit-serial
// divider; a laser event takes a shift-add multiply and one division. The
// result register lets the next transaction be taken while a result still
// waits at the output.
`timescale 1ns / 1ps
`default_nettype none
module stepper_ramp_homing_pulse_generator
    import srg_pkg::*;
#(
    parameter int SPEED_FRAC_BITS = SPEED_FRAC_BITS_DEF,
    parameter int TIME_WIDTH      = TIME_WIDTH_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_stall,
    input  wire logic                   i_req_type,
    input  wire logic [NOW_W-1:0]       i_now_us,
    input  wire logic                   i_laser_level,
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output logic                        o_step_out,
    output logic                        o_dir_out,
    output logic signed [COUNT_W-1:0]   o_position,
    output logic signed [COUNT_W-1:0]   o_measured_position,
    output logic [1:0]                  o_mode,
    output logic [SPEED_INT_W-1:0]      o_speed,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data
);
    t_dp_cmd  cmd;
    t_dp_stat stat;

    // configuration is always taken
    assign o_cfg_ready = 1'b1;

    srg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    srg_datapath #(
        .SPEED_FRAC_BITS (SPEED_FRAC_BITS),
        .TIME_WIDTH      (TIME_WIDTH)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_stat              (stat),
        .i_req_type          (i_req_type),
        .i_now_us            (i_now_us),
        .i_laser_level       (i_laser_level),
        .i_cfg_we            (i_cfg_valid),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_out_stall         (i_out_stall),
        .o_out_valid         (o_out_valid),
        .o_step_out          (o_step_out),
        .o_dir_out           (o_dir_out),
        .o_position          (o_position),
        .o_measured_position (o_measured_position),
        .o_mode              (o_mode),
        .o_speed             (o_speed)
    );

endmodule
`default_nettype wire

[rtl/core/srg_divider.sv]
// restoring divider, one quotient bit per cycle, saturating quotient
`timescale 1ns / 1ps
`default_nettype none
module srg_divider
    import srg_pkg::*;
#(
    parameter int NUM_W = 66,
    parameter int DEN_W = 36
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [NUM_W-1:0]  i_num,
    input  wire logic [DEN_W-1:0]  i_den,
    output logic                   o_done,
    output logic [QUOT_W-1:0]      o_quot
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DEN_W:0]        trial;
    logic                  qbit;
    logic [NUM_W+QUOT_W-1:0] qx;
    logic                  sat;

    // one trial subtraction
    always_comb begin
        trial = {r_rem, r_num[NUM_W-1]};
        qbit  = (trial >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // operand and partial remainder registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_rem <= '0;
            r_den <= (i_den == '0) ? DEN_W'(1) : i_den;
        end else if (r_busy) begin
            r_num <= {r_num[NUM_W-2:0], qbit};
            r_rem <= qbit ? DEN_W'(trial - {1'b0, r_den}) : trial[DEN_W-1:0];
        end
    end

    // saturate at the cap
    always_comb begin
        qx  = {{QUOT_W{1'b0}}, r_num};
        sat = 1'b0;
        for (int i = QUOT_W - 1; i < NUM_W + QUOT_W; i++) begin
            sat = sat | qx[i];
        end
        o_quot = (sat && (qx[QUOT_W-2:0] != '0 || qx[NUM_W+QUOT_W-1:QUOT_W] != '0))
                 ? QCAP : (sat ? QCAP : qx[QUOT_W-1:0]);
    end

    assign o_done = r_done;

endmodule
`default_nettype wire

[rtl/core/srg_datapath.sv]
// speed, position, timing and configuration registers with the shared divider
`timescale 1ns / 1ps
`default_nettype none
module srg_datapath
    import srg_pkg::*;
#(
    parameter int SPEED_FRAC_BITS = SPEED_FRAC_BITS_DEF,
    parameter int TIME_WIDTH      = TIME_WIDTH_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_dp_cmd                i_cmd,
    output t_dp_stat                    o_stat,
    input  wire logic                   i_req_type,
    input  wire logic [NOW_W-1:0]       i_now_us,
    input  wire logic                   i_laser_level,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                   i_out_stall,
    output logic                        o_out_valid,
    output logic                        o_step_out,
    output logic                        o_dir_out,
    output logic signed [COUNT_W-1:0]   o_position,
    output logic signed [COUNT_W-1:0]   o_measured_position,
    output logic [1:0]                  o_mode,
    output logic [SPEED_INT_W-1:0]      o_speed
);
    localparam int F      = SPEED_FRAC_BITS;
    localparam int TW     = TIME_WIDTH;
    localparam int SW     = SPEED_INT_W + F;
    localparam int RW     = ACCEL_W + F;
    localparam int PW     = SW + USEC_W;
    localparam int NUM_W  = PW + F;
    localparam int DEN_W  = DTIME_W + F;
    localparam int WW     = 64;
    localparam int MCNT_W = $clog2(USEC_W);

    // configuration registers
    logic [SPEED_INT_W-1:0] r_min, r_mid, r_max;
    logic [ACCEL_W-1:0]     r_acc_slow, r_acc_fast;
    logic [DTIME_W-1:0]     r_dtime;
    logic [PWIDTH_W-1:0]    r_pwidth;

    // channel state
    logic [SW-1:0]     r_speed;
    logic [1:0]        r_mode;
    logic              r_dir;
    logic [COUNT_W-1:0] r_count, r_capt;
    logic [TW-1:0]     r_last, r_pstart;
    logic              r_pact, r_plevel;
    logic [IVAL_W-1:0] r_ival;
    logic [RW-1:0]     r_rate;

    // item and scratch registers
    logic              r_req, r_laser;
    logic [TW-1:0]     r_now;
    logic [WW-1:0]     r_spw;
    logic [PW-1:0]     r_prod, r_mcand;
    logic [USEC_W-1:0] r_mbits;
    logic [MCNT_W-1:0] r_mcnt;

    // output register
    logic              r_ovalid;

    logic [WW-1:0]     minf, midf, maxf, speed_w, delta_w, q_w;
    logic [TW-1:0]     dt_step, dt_pulse;
    logic              div_start, div_done;
    logic [NUM_W-1:0]  div_num;
    logic [DEN_W-1:0]  div_den;
    logic [QUOT_W-1:0] div_q;

    // fixed point limits and elapsed times
    always_comb begin
        minf     = WW'({r_min, {F{1'b0}}});
        midf     = WW'({r_mid, {F{1'b0}}});
        maxf     = WW'({r_max, {F{1'b0}}});
        speed_w  = WW'(r_speed);
        delta_w  = WW'(div_q);
        q_w      = WW'(div_q);
        dt_step  = r_now - r_last;
        dt_pulse = r_now - r_pstart;
    end

    // divider operand selection
    always_comb begin
        div_start = (i_cmd.mark_step && r_mode != MODE_STOP) || i_cmd.do_step ||
                    i_cmd.start_rate;
        div_num   = NUM_W'({USEC, {F{1'b0}}});
        div_den   = DEN_W'(r_speed);
        if (i_cmd.start_rate) begin
            div_num = NUM_W'(r_prod);
            div_den = DEN_W'(r_dtime);
        end else if (i_cmd.mark_step) begin
            unique case (r_mode)
                MODE_SLOW: div_num = NUM_W'({r_acc_slow, {(2*F){1'b0}}});
                MODE_FAST: div_num = NUM_W'({r_acc_fast, {(2*F){1'b0}}});
                MODE_DEC:  div_num = NUM_W'({r_rate, {F{1'b0}}});
                MODE_STOP: div_num = NUM_W'({USEC, {F{1'b0}}});
            endcase
        end
    end

    srg_divider #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    // status to the controller
    always_comb begin
        o_stat.is_laser  = r_req;
        o_stat.elapsed   = (WW'(dt_step) >= WW'(r_ival));
        o_stat.mode_zero = (r_mode == MODE_STOP);
        o_stat.mul_last  = (r_mcnt == MCNT_W'(USEC_W - 1));
        o_stat.div_done  = div_done;
        o_stat.out_free  = !r_ovalid || !i_out_stall;
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min      <= RST_MIN_SPEED;
            r_mid      <= RST_MID_SPEED;
            r_max      <= RST_MAX_SPEED;
            r_acc_slow <= RST_ACCEL_SLOW;
            r_acc_fast <= RST_ACCEL_FAST;
            r_dtime    <= RST_DECEL_TIME;
            r_pwidth   <= RST_PULSE_W;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MIN_SPEED:  r_min      <= i_cfg_data[SPEED_INT_W-1:0];
                CFG_MID_SPEED:  r_mid      <= i_cfg_data[SPEED_INT_W-1:0];
                CFG_MAX_SPEED:  r_max      <= i_cfg_data[SPEED_INT_W-1:0];
                CFG_ACCEL_SLOW: r_acc_slow <= i_cfg_data[ACCEL_W-1:0];
                CFG_ACCEL_FAST: r_acc_fast <= i_cfg_data[ACCEL_W-1:0];
                CFG_DECEL_TIME: r_dtime    <= i_cfg_data[DTIME_W-1:0];
                CFG_PULSE_W:    r_pwidth   <= i_cfg_data[PWIDTH_W-1:0];
                default: ;
            endcase
        end
    end

    // input transaction capture and scratch registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_req   <= i_req_type;
            r_now   <= TW'(i_now_us);
            r_laser <= i_laser_level;
        end
        if (i_cmd.upd_speed) begin
            unique case (r_mode)
                MODE_SLOW, MODE_FAST: r_spw <= speed_w + delta_w;
                MODE_DEC: r_spw <= (speed_w < delta_w + minf) ? minf : speed_w - delta_w;
                MODE_STOP: r_spw <= speed_w;
            endcase
        end
        // shift and add multiply by one second
        if (i_cmd.laser_cap) begin
            r_prod  <= '0;
            r_mcand <= PW'(r_speed);
            r_mbits <= USEC;
            r_mcnt  <= '0;
        end else if (i_cmd.mul_step) begin
            if (r_mbits[0]) begin
                r_prod <= r_prod + r_mcand;
            end
            r_mcand <= {r_mcand[PW-2:0], 1'b0};
            r_mbits <= {1'b0, r_mbits[USEC_W-1:1]};
            r_mcnt  <= r_mcnt + 1'b1;
        end
    end

    // channel state updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed  <= SW'({RST_MIN_SPEED, {F{1'b0}}});
            r_mode   <= MODE_SLOW;
            r_dir    <= 1'b1;
            r_count  <= '0;
            r_capt   <= '0;
            r_last   <= '0;
            r_pstart <= '0;
            r_pact   <= 1'b0;
            r_plevel <= 1'b0;
            r_ival   <= '0;
            r_rate   <= RW'({RST_DECEL_RATE, {F{1'b0}}});
        end else begin
            if (i_cmd.fall_chk && r_pact && WW'(dt_pulse) >= WW'(r_pwidth)) begin
                r_pact   <= 1'b0;
                r_plevel <= 1'b0;
            end
            if (i_cmd.mark_step) begin
                r_last <= r_now;
            end
            // mode changes of the speed update
            if (i_cmd.upd_speed) begin
                if (r_mode == MODE_SLOW && speed_w + delta_w > midf) begin
                    r_mode <= MODE_FAST;
                end
                if (r_mode == MODE_DEC && speed_w < delta_w + minf) begin
                    r_mode <= MODE_SLOW;
                    r_dir  <= !r_laser;
                end
            end
            // minimum test then maximum clamp
            if (i_cmd.limit) begin
                if (r_spw < minf) begin
                    r_mode <= MODE_STOP;
                end
                r_speed <= (r_spw > maxf) ? maxf[SW-1:0] : r_spw[SW-1:0];
            end
            if (i_cmd.do_step) begin
                r_plevel <= 1'b1;
                r_pact   <= 1'b1;
                r_pstart <= r_now;
                r_count  <= r_dir ? r_count + 1'b1 : r_count - 1'b1;
            end
            if (i_cmd.park) begin
                r_speed <= minf[SW-1:0];
            end
            if (i_cmd.set_ival) begin
                r_ival <= (q_w > WW'({IVAL_W{1'b1}})) ? {IVAL_W{1'b1}} : q_w[IVAL_W-1:0];
            end
            if (i_cmd.laser_cap && !r_laser && r_mode == MODE_SLOW) begin
                r_capt <= r_count;
            end
            if (i_cmd.set_rate) begin
                r_rate <= (q_w > WW'({RW{1'b1}})) ? {RW{1'b1}} : q_w[RW-1:0];
                r_mode <= MODE_DEC;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (!i_out_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_step_out          <= r_plevel;
            o_dir_out           <= r_dir;
            o_position          <= r_count;
            o_measured_position <= r_capt;
            o_mode              <= r_mode;
            o_speed             <= r_speed[SW-1:F];
        end
    end

    assign o_out_valid = r_ovalid;

endmodule
`default_nettype wire

[rtl/core/srg_ctrl.sv]
// sequencing state machine for ticks and laser events
`timescale 1ns / 1ps
`default_nettype none
module srg_ctrl
    import srg_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DISP   = 4'd1;
    localparam logic [3:0] S_ADIV   = 4'd2;
    localparam logic [3:0] S_UPD    = 4'd3;
    localparam logic [3:0] S_LIM    = 4'd4;
    localparam logic [3:0] S_STEP   = 4'd5;
    localparam logic [3:0] S_IDIV   = 4'd6;
    localparam logic [3:0] S_MUL    = 4'd7;
    localparam logic [3:0] S_RSTART = 4'd8;
    localparam logic [3:0] S_RDIV   = 4'd9;
    localparam logic [3:0] S_DONE   = 4'd10;

    logic [3:0] r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                if (i_stat.is_laser) begin
                    o_cmd.laser_cap = 1'b1;
                    n_state = S_MUL;
                end else if (i_stat.elapsed) begin
                    o_cmd.mark_step = 1'b1;
                    n_state = i_stat.mode_zero ? S_UPD : S_ADIV;
                end else begin
                    o_cmd.fall_chk = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_ADIV: begin
                if (i_stat.div_done) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                o_cmd.upd_speed = 1'b1;
                n_state = S_LIM;
            end
            S_LIM: begin
                o_cmd.limit = 1'b1;
                n_state = S_STEP;
            end
            S_STEP: begin
                if (i_stat.mode_zero) begin
                    o_cmd.park = 1'b1;
                    n_state = S_DONE;
                end else begin
                    o_cmd.do_step = 1'b1;
                    n_state = S_IDIV;
                end
            end
            S_IDIV: begin
                if (i_stat.div_done) begin
                    o_cmd.set_ival = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_MUL: begin
                o_cmd.mul_step = 1'b1;
                if (i_stat.mul_last) begin
                    n_state = S_RSTART;
                end
            end
            S_RSTART: begin
                o_cmd.start_rate = 1'b1;
                n_state = S_RDIV;
            end
            S_RDIV: begin
                if (i_stat.div_done) begin
                    o_cmd.set_rate = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire
